// ===== rtl/core/lsbbp_pkg.sv =====
package lsbbp_pkg;

  // field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned NbitsW = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxField = 32;

  // default store depth in bytes
  localparam int unsigned DefaultBufferBytes = 32;

  // request codes
  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ALIGN = 6'b000010,
    ST_PLACE = 6'b000100,
    ST_RESP  = 6'b001000,
    ST_DRD   = 6'b010000,
    ST_DOUT  = 6'b100000
  } state_e;

  // low bit masks, 0 to 8 bits
  function automatic logic [ByteW-1:0] low_mask(input logic [3:0] n);
    logic [ByteW-1:0] m;
    case (n)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd3:    m = 8'h07;
      4'd4:    m = 8'h0f;
      4'd5:    m = 8'h1f;
      4'd6:    m = 8'h3f;
      4'd7:    m = 8'h7f;
      default: m = 8'hff;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/lsb_first_bit_packer_top.sv =====
// LSB-first bit packer. An add request places the low nbits (0 to 32, larger
// counts saturate to 32) of value after the bits already held in a byte store
// of BUFFER_BYTES entries; if the store fills part way, the bits not placed
// are reported as pending and the next add places only its upper pending
// bits. Every add gives one result (full flag, pending count, last set). A
// drain request gives one result per complete byte in store order, last set on
// the final one, and empties the store while keeping the partial byte. One
// shared step unit places up to eight bits a cycle and writes at most one
// completed byte a cycle into the single-port store. An add passes from
// acceptance to its result through an align step, one place step per byte
// the field touches, up to five, a closing step and a result step; an add
// to a full store goes from the align step straight to the result step. A
// drain reads each byte through the registered store read before it is
// presented. Input is taken only while the sequencer is idle; results leave
// through an output register.
module lsb_first_bit_packer_top #(
  parameter int unsigned BUFFER_BYTES = lsbbp_pkg::DefaultBufferBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [lsbbp_pkg::ValueW-1:0]  value_i,
  input  logic [lsbbp_pkg::NbitsW-1:0]  nbits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          full_res_o,
  output logic [lsbbp_pkg::NbitsW-1:0]  pending_bits_o,
  output logic [lsbbp_pkg::ByteW-1:0]   data_byte_o,
  output logic                          last_o
);

  localparam int unsigned AddrW  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned CountW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CountW-1:0] CountFull = CountW'(BUFFER_BYTES);

  localparam int unsigned VW = lsbbp_pkg::ValueW;
  localparam int unsigned NW = lsbbp_pkg::NbitsW;
  localparam int unsigned BW = lsbbp_pkg::ByteW;

  lsbbp_pkg::state_e state_q, state_d;

  logic [CountW-1:0] count_q, count_d;
  logic [2:0]        pos_q, pos_d;
  logic [NW-1:0]     pend_q, pend_d;
  logic [BW-1:0]     part_q, part_d;
  logic [VW-1:0]     v_q, v_d;
  logic [NW-1:0]     left_q, left_d;
  logic [CountW-1:0] k_q, k_d;

  logic              out_valid_q, out_valid_d;
  logic              full_q, full_d;
  logic [NW-1:0]     pbits_q, pbits_d;
  logic [BW-1:0]     dbyte_q, dbyte_d;
  logic              last_q, last_d;

  logic [BW-1:0]     mem_q [BUFFER_BYTES];
  logic [BW-1:0]     rd_q;
  logic              rd_en;
  logic              wr_en;
  logic [BW-1:0]     wr_data;

  logic              slot_free;
  logic              is_full;
  logic [NW-1:0]     nbits_sat;
  logic [NW-1:0]     shamt;
  logic [3:0]        room;
  logic [3:0]        take;
  logic [BW-1:0]     piece;
  logic [BW-1:0]     piece_sh;
  logic [BW-1:0]     merged;
  logic [3:0]        pos_sum;
  logic [CountW-1:0] k_next;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_full   = (count_q >= CountFull);
  assign nbits_sat = nbits_i[NW-1] ? NW'(lsbbp_pkg::MaxField) : nbits_i;
  assign shamt     = (pend_q > left_q) ? '0 : NW'(left_q - pend_q);
  assign k_next    = k_q + CountW'(1);

  // shared step unit: place up to the rest of the current byte
  assign room     = 4'd8 - {1'b0, pos_q};
  assign take     = ({2'b00, left_q} < {4'b0000, room}) ? left_q[3:0] : room;
  assign piece    = v_q[BW-1:0] & lsbbp_pkg::low_mask(take);
  assign piece_sh = piece << pos_q;
  assign merged   = part_q | piece_sh;
  assign pos_sum  = {1'b0, pos_q} + take;

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    part_d      = part_q;
    v_d         = v_q;
    left_d      = left_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    full_d      = full_q;
    pbits_d     = pbits_q;
    dbyte_d     = dbyte_q;
    last_d      = last_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = merged;

    unique case (state_q)
      lsbbp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          v_d    = value_i;
          left_d = nbits_sat;
          k_d    = '0;
          if (func_i == lsbbp_pkg::FUNC_ADD) begin
            state_d = lsbbp_pkg::ST_ALIGN;
          end else if (count_q != '0) begin
            state_d = lsbbp_pkg::ST_DRD;
          end
        end
      end
      lsbbp_pkg::ST_ALIGN: begin
        if (is_full) begin
          state_d = lsbbp_pkg::ST_RESP;
        end else begin
          if (pend_q != '0) begin
            v_d    = v_q >> shamt;
            left_d = pend_q;
          end
          state_d = lsbbp_pkg::ST_PLACE;
        end
      end
      lsbbp_pkg::ST_PLACE: begin
        if (!is_full && left_q != '0) begin
          v_d    = v_q >> take;
          left_d = left_q - NW'(take);
          if (pos_sum[3]) begin
            wr_en   = 1'b1;
            count_d = count_q + CountW'(1);
            pos_d   = '0;
            part_d  = '0;
          end else begin
            pos_d  = pos_sum[2:0];
            part_d = merged;
          end
        end else begin
          pend_d  = left_q;
          state_d = lsbbp_pkg::ST_RESP;
        end
      end
      lsbbp_pkg::ST_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          full_d      = is_full;
          pbits_d     = pend_q;
          dbyte_d     = '0;
          last_d      = 1'b1;
          state_d     = lsbbp_pkg::ST_IDLE;
        end
      end
      lsbbp_pkg::ST_DRD: begin
        rd_en   = 1'b1;
        state_d = lsbbp_pkg::ST_DOUT;
      end
      lsbbp_pkg::ST_DOUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          full_d      = 1'b0;
          pbits_d     = pend_q;
          dbyte_d     = rd_q;
          last_d      = (k_next == count_q);
          k_d         = k_next;
          if (k_next == count_q) begin
            count_d = '0;
            state_d = lsbbp_pkg::ST_IDLE;
          end else begin
            state_d = lsbbp_pkg::ST_DRD;
          end
        end
      end
      default: begin
        state_d = lsbbp_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsbbp_pkg::ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      pend_q      <= '0;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    left_q  <= left_d;
    k_q     <= k_d;
    full_q  <= full_d;
    pbits_q <= pbits_d;
    dbyte_q <= dbyte_d;
    last_q  <= last_d;
  end

  // byte store, one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AddrW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[k_q[AddrW-1:0]];
    end
  end

  assign in_ready_o     = (state_q == lsbbp_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign full_res_o     = full_q;
  assign pending_bits_o = pbits_q;
  assign data_byte_o    = dbyte_q;
  assign last_o         = last_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("byte count beyond store depth");

  a_full_no_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_full |-> (pos_q == '0))
    else $error("partial byte held in a full store");

  a_part_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (part_q & ~lsbbp_pkg::low_mask({1'b0, pos_q})) == '0)
    else $error("partial byte has bits above its position");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= NW'(lsbbp_pkg::MaxField))
    else $error("pending count above field width");

endmodule
